### rtl/rmq_pkg.sv
// Shared types for the rotation matrix to quaternion converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

  // Which Shepperd case an item takes: positive trace, or the dominant diagonal axis.
  typedef enum logic [1:0] {
    SEL_TRACE,
    SEL_X,
    SEL_Y,
    SEL_Z
  } sel_t;

endpackage

`default_nettype wire

### rtl/rmq_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the quaternion converter.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps
`default_nettype none

module rmq_div #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic [2*SAMPLE_WIDTH-1:0]     num,
  input  wire logic [SAMPLE_WIDTH:0]         den,
  output logic      [SAMPLE_WIDTH-1:0]       quo,
  output logic                               ovf
);

  localparam int F  = SAMPLE_WIDTH - 1;
  localparam int NW = 2 * F + 2;

  logic [F+1:0] rem  [F+1];
  logic [F:0]   lo   [F+1];
  logic [F+1:0] dv   [F+1];
  logic [F:0]   q    [F+2];
  logic         of   [F+2];

  // The high part of the dividend seeds the remainder; if it already reaches the
  // divisor, the quotient needs more bits than kept and the result saturates.
  assign rem[0] = {1'b0, num[NW-1:F+1]};
  assign lo[0]  = num[F:0];
  assign dv[0]  = den;
  assign q[0]   = '0;
  assign of[0]  = ({1'b0, num[NW-1:F+1]} >= den);

  for (genvar k = 0; k <= F; k++) begin : g_step
    logic [F+2:0] cur;
    logic         ge;
    assign cur = {rem[k], lo[k][F]};
    assign ge  = (cur >= {1'b0, dv[k]});
    always_ff @(posedge clk) begin
      q[k+1]  <= {q[k][F-1:0], ge};
      of[k+1] <= of[k];
    end
    if (k < F) begin : g_carry
      always_ff @(posedge clk) begin
        rem[k+1] <= ge ? (F+2)'(cur - {1'b0, dv[k]}) : cur[F+1:0];
        lo[k+1]  <= {lo[k][F-1:0], 1'b0};
        dv[k+1]  <= dv[k];
      end
    end
  end

  assign quo = q[F+1];
  assign ovf = of[F+1];

endmodule

`default_nettype wire

### rtl/rotation_matrix_to_quaternion.sv
// Pipeline: input register, case selection, the bit-per-stage square root, divider
// operands, the bit-per-stage divider and the output register.
// Throughput: one transaction per clock cycle while busy is low; the pipeline never stalls.
// Reset (synchronous, active high) empties the pipeline and holds busy high for one
// cycle after it; results never wait on the receiver, so busy is low otherwise.
// Top level of the Shepperd rotation matrix to quaternion converter; uses rmq_pkg, rmq_div.
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [SAMPLE_WIDTH-1:0] r1c1,
  input  wire logic signed [SAMPLE_WIDTH-1:0] r1c2,
  input  wire logic signed [SAMPLE_WIDTH-1:0] r1c3,
  input  wire logic signed [SAMPLE_WIDTH-1:0] r2c1,
  input  wire logic signed [SAMPLE_WIDTH-1:0] r2c2,
  input  wire logic signed [SAMPLE_WIDTH-1:0] r2c3,
  input  wire logic signed [SAMPLE_WIDTH-1:0] r3c1,
  input  wire logic signed [SAMPLE_WIDTH-1:0] r3c2,
  input  wire logic signed [SAMPLE_WIDTH-1:0] r3c3,
  output logic                                strobe,
  output logic signed [SAMPLE_WIDTH-1:0]      quat_x,
  output logic signed [SAMPLE_WIDTH-1:0]      quat_y,
  output logic signed [SAMPLE_WIDTH-1:0]      quat_z,
  output logic signed [SAMPLE_WIDTH-1:0]      quat_w
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int F   = W - 1;
  localparam int XW  = 2 * F + 2;   // radicand shifted up by F fractional bits
  localparam int NS  = 2 * F + 6;   // number of valid stages
  localparam logic signed [W+1:0] UNIT = {2'b00, 1'b1, {F{1'b0}}};

  typedef logic signed [W-1:0] samp_t;
  typedef logic signed [W:0]   num_t;

  logic [NS-1:0] vld;

  // Stage A: registered input matrix.
  samp_t a_m [9];

  // Stage B: case selection, clamped radicand and the three off-diagonal terms.
  sel_t       b_sel;
  logic [F+1:0] b_rad;
  num_t       b_d [3];

  // Square root pipeline, one root bit per stage.
  logic [F+1:0] sq_rem  [F+1];
  logic [XW-1:0] sq_x   [F+1];
  logic [F:0]   sq_root [F+2];
  sel_t         sq_sel  [F+2];
  num_t         sq_d    [F+2][3];

  // Stage P: divider operands.
  logic [2*F+1:0] p_num [3];
  logic [F+1:0]   p_den;

  // Side data that travels alongside the dividers.
  sel_t       dv_sel  [F+2];
  logic [F:0] dv_half [F+2];
  logic [2:0] dv_neg  [F+2];

  logic [F:0] quo [3];
  logic       ovf [3];

  // Saturate a magnitude to the signed range and apply its sign.
  function automatic samp_t sat_q(input logic neg, input logic ov, input logic [F:0] mag);
    logic [F:0] lim;
    logic [F:0] m;
    lim = neg ? {1'b1, {F{1'b0}}} : {1'b0, {F{1'b1}}};
    m   = (ov || (mag > lim)) ? lim : mag;
    return neg ? samp_t'(-{1'b0, m}) : samp_t'({1'b0, m});
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[NS-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    a_m[0] <= r1c1; a_m[1] <= r1c2; a_m[2] <= r1c3;
    a_m[3] <= r2c1; a_m[4] <= r2c2; a_m[5] <= r2c3;
    a_m[6] <= r3c1; a_m[7] <= r3c2; a_m[8] <= r3c3;
  end

  // Case selection follows the method with strict compares, so ties fall to the
  // later case. A radicand at or below zero only arises for non-rotation input and
  // is forced to one LSB, which keeps the divisor above zero.
  always_ff @(posedge clk) begin
    logic signed [W+1:0] m11, m22, m33, trace, rad;
    sel_t sel;
    m11   = (W+2)'(a_m[0]);
    m22   = (W+2)'(a_m[4]);
    m33   = (W+2)'(a_m[8]);
    trace = m11 + m22 + m33;
    if (trace > 0) begin
      sel = SEL_TRACE;
      rad = trace + UNIT;
    end else if (m11 > m22 && m11 > m33) begin
      sel = SEL_X;
      rad = UNIT + m11 - m22 - m33;
    end else if (m22 > m33) begin
      sel = SEL_Y;
      rad = UNIT + m22 - m11 - m33;
    end else begin
      sel = SEL_Z;
      rad = UNIT + m33 - m11 - m22;
    end
    b_sel <= sel;
    b_rad <= (rad > 0) ? rad[F+1:0] : (F+2)'(1);
    // Terms in divider order: the first always ends up in w unless w is the half root.
    unique case (sel)
      SEL_TRACE: begin
        b_d[0] <= num_t'(a_m[7]) - num_t'(a_m[5]);
        b_d[1] <= num_t'(a_m[2]) - num_t'(a_m[6]);
        b_d[2] <= num_t'(a_m[3]) - num_t'(a_m[1]);
      end
      SEL_X: begin
        b_d[0] <= num_t'(a_m[7]) - num_t'(a_m[5]);
        b_d[1] <= num_t'(a_m[1]) + num_t'(a_m[3]);
        b_d[2] <= num_t'(a_m[2]) + num_t'(a_m[6]);
      end
      SEL_Y: begin
        b_d[0] <= num_t'(a_m[2]) - num_t'(a_m[6]);
        b_d[1] <= num_t'(a_m[1]) + num_t'(a_m[3]);
        b_d[2] <= num_t'(a_m[5]) + num_t'(a_m[7]);
      end
      SEL_Z: begin
        b_d[0] <= num_t'(a_m[3]) - num_t'(a_m[1]);
        b_d[1] <= num_t'(a_m[2]) + num_t'(a_m[6]);
        b_d[2] <= num_t'(a_m[5]) + num_t'(a_m[7]);
      end
    endcase
  end

  // Floor square root of rad << F, two radicand bits consumed per stage.
  assign sq_rem[0]  = '0;
  assign sq_x[0]    = {b_rad, {F{1'b0}}};
  assign sq_root[0] = '0;
  assign sq_sel[0]  = b_sel;
  assign sq_d[0]    = b_d;

  for (genvar k = 0; k <= F; k++) begin : g_sqrt
    logic [F+3:0] cur;
    logic [F+3:0] trial;
    logic         ge;
    assign cur   = {sq_rem[k], sq_x[k][XW-1:XW-2]};
    assign trial = {1'b0, sq_root[k], 2'b01};
    assign ge    = (cur >= trial);
    always_ff @(posedge clk) begin
      sq_root[k+1] <= {sq_root[k][F-1:0], ge};
      sq_sel[k+1]  <= sq_sel[k];
      sq_d[k+1]    <= sq_d[k];
    end
    if (k < F) begin : g_carry
      always_ff @(posedge clk) begin
        sq_rem[k+1] <= ge ? (F+2)'(cur - trial) : cur[F+1:0];
        sq_x[k+1]   <= {sq_x[k][XW-3:0], 2'b00};
      end
    end
  end

  // Divider operands: |d| << F plus half the divisor rounds the quotient to nearest.
  // The half root keeps F+1 bits so that a full-scale root saturates instead of wrapping.
  always_ff @(posedge clk) begin
    logic [F:0] root;
    logic [W:0] mag;
    root = sq_root[F+1];
    p_den <= {root, 1'b0};
    dv_sel[0]  <= sq_sel[F+1];
    dv_half[0] <= (F+1)'(({1'b0, root} + (F+2)'(1)) >> 1);
    for (int i = 0; i < 3; i++) begin
      mag = sq_d[F+1][i][W] ? (W+1)'(-sq_d[F+1][i]) : sq_d[F+1][i];
      dv_neg[0][i] <= sq_d[F+1][i][W];
      p_num[i]     <= {mag, {F{1'b0}}} + (2*F+2)'(root);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    rmq_div #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_div (
      .clk (clk),
      .num (p_num[i]),
      .den (p_den),
      .quo (quo[i]),
      .ovf (ovf[i])
    );
  end

  for (genvar k = 0; k <= F; k++) begin : g_side
    always_ff @(posedge clk) begin
      dv_sel[k+1]  <= dv_sel[k];
      dv_half[k+1] <= dv_half[k];
      dv_neg[k+1]  <= dv_neg[k];
    end
  end

  // Output register: saturate and place each component by case.
  always_ff @(posedge clk) begin
    samp_t h, q0, q1, q2;
    h  = sat_q(1'b0, 1'b0, dv_half[F+1]);
    q0 = sat_q(dv_neg[F+1][0], ovf[0], quo[0]);
    q1 = sat_q(dv_neg[F+1][1], ovf[1], quo[1]);
    q2 = sat_q(dv_neg[F+1][2], ovf[2], quo[2]);
    unique case (dv_sel[F+1])
      SEL_TRACE: begin
        quat_x <= q0; quat_y <= q1; quat_z <= q2; quat_w <= h;
      end
      SEL_X: begin
        quat_x <= h;  quat_y <= q1; quat_z <= q2; quat_w <= q0;
      end
      SEL_Y: begin
        quat_x <= q1; quat_y <= h;  quat_z <= q2; quat_w <= q0;
      end
      SEL_Z: begin
        quat_x <= q1; quat_y <= q2; quat_z <= h;  quat_w <= q0;
      end
    endcase
  end

  assign strobe = vld[NS-1];

endmodule

`default_nettype wire

### rtl/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion converter, with its bind.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none

module rmq_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic signed [SAMPLE_WIDTH-1:0] quat_x,
  input wire logic signed [SAMPLE_WIDTH-1:0] quat_y,
  input wire logic signed [SAMPLE_WIDTH-1:0] quat_z,
  input wire logic signed [SAMPLE_WIDTH-1:0] quat_w,
  input wire logic                           strobe
);

  localparam int LAT = 2 * SAMPLE_WIDTH + 4;

  // Every result traces back to a transaction that was accepted at the input.
  a_lat : assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start & ~busy, LAT)) else $error("result without matching transaction");

  // Busy is high only in the cycle right after reset.
  a_busy : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !busy) else $error("busy outside reset recovery");

  // Not all four components are negative at once: the half-root component never is.
  a_sign : assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(quat_x[SAMPLE_WIDTH-1] && quat_y[SAMPLE_WIDTH-1] &&
                 quat_z[SAMPLE_WIDTH-1] && quat_w[SAMPLE_WIDTH-1]))
    else $error("all quaternion components negative");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_rmq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .quat_x (quat_x),
  .quat_y (quat_y),
  .quat_z (quat_z),
  .quat_w (quat_w),
  .strobe (strobe)
);

`default_nettype wire

### verif/rotation_matrix_to_quaternion_test.sv
// Self-checking testbench for the rotation matrix to quaternion converter.
// Depends on rmq_pkg and rotation_matrix_to_quaternion; a built-in predictor computes each quaternion.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  localparam int W = 16;
  localparam int FRAC = W - 1;
  localparam longint UNIT = longint'(1) << FRAC;
  // Pipeline depth of the top level; the watchdog limit adds margin.
  localparam int LATENCY = 2 * W + 4;
  localparam int WATCHDOG_LIMIT = 4 * LATENCY + 200;

  typedef logic signed [W-1:0] sample_t;
  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
    sample_t w;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  sample_t r1c1 = '0, r1c2 = '0, r1c3 = '0;
  sample_t r2c1 = '0, r2c2 = '0, r2c3 = '0;
  sample_t r3c1 = '0, r3c2 = '0, r3c3 = '0;
  logic strobe;
  sample_t quat_x, quat_y, quat_z, quat_w;

  quat_t expected_quats[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  always #1 clk = ~clk;

  rotation_matrix_to_quaternion #(.SAMPLE_WIDTH(W)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .r1c1(r1c1), .r1c2(r1c2), .r1c3(r1c3),
    .r2c1(r2c1), .r2c2(r2c2), .r2c3(r2c3),
    .r3c1(r3c1), .r3c2(r3c2), .r3c3(r3c3),
    .strobe(strobe),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
  );

  // Floor of the exact square root, one result bit per pass.
  function automatic longint unsigned floor_sqrt(longint unsigned val);
    longint unsigned rem, root, probe;
    rem = val;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic sample_t clamp_q(bit neg, longint unsigned mag);
    longint unsigned lim;
    lim = neg ? longint'(UNIT) : longint'(UNIT) - 1;
    if (mag > lim) mag = lim;
    return neg ? sample_t'(-longint'(mag)) : sample_t'(mag);
  endfunction

  // Signed numerator over a positive divisor; magnitude rounds half away from zero.
  function automatic sample_t rounded_quotient(longint num, longint unsigned den);
    bit neg;
    longint unsigned mag;
    neg = num < 0;
    mag = neg ? longint'(-num) : longint'(num);
    return clamp_q(neg, ((mag << FRAC) + (den >> 1)) / den);
  endfunction

  function automatic quat_t predict_quaternion(sample_t m[9]);
    longint a11, a12, a13, a21, a22, a23, a31, a32, a33, trace, rad;
    longint unsigned root, den;
    sample_t half;
    sel_t branch;
    quat_t q;
    a11 = m[0]; a12 = m[1]; a13 = m[2];
    a21 = m[3]; a22 = m[4]; a23 = m[5];
    a31 = m[6]; a32 = m[7]; a33 = m[8];
    trace = a11 + a22 + a33;
    if (trace > 0) begin
      branch = SEL_TRACE; rad = trace + UNIT;
    end else if (a11 > a22 && a11 > a33) begin
      branch = SEL_X; rad = UNIT + a11 - a22 - a33;
    end else if (a22 > a33) begin
      branch = SEL_Y; rad = UNIT + a22 - a11 - a33;
    end else begin
      branch = SEL_Z; rad = UNIT + a33 - a11 - a22;
    end
    // Clamp a radicand at or below zero to one LSB, as the design does.
    if (rad <= 0) rad = 1;
    root = floor_sqrt(longint'(rad) << FRAC);
    den = root << 1;
    half = clamp_q(1'b0, (root + 1) >> 1);
    case (branch)
      SEL_TRACE: begin
        q.w = half;
        q.x = rounded_quotient(a32 - a23, den);
        q.y = rounded_quotient(a13 - a31, den);
        q.z = rounded_quotient(a21 - a12, den);
      end
      SEL_X: begin
        q.w = rounded_quotient(a32 - a23, den);
        q.x = half;
        q.y = rounded_quotient(a12 + a21, den);
        q.z = rounded_quotient(a13 + a31, den);
      end
      SEL_Y: begin
        q.w = rounded_quotient(a13 - a31, den);
        q.x = rounded_quotient(a12 + a21, den);
        q.y = half;
        q.z = rounded_quotient(a23 + a32, den);
      end
      default: begin
        q.w = rounded_quotient(a21 - a12, den);
        q.x = rounded_quotient(a13 + a31, den);
        q.y = rounded_quotient(a23 + a32, den);
        q.z = half;
      end
    endcase
    return q;
  endfunction

  task automatic report_mismatch(string what, sample_t got, sample_t want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Send one matrix. A random gap with start low may precede the transaction; start
  // stays high across back-to-back transactions so it is never lowered and raised
  // in the same step.
  task automatic send_matrix(sample_t m[9]);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    r1c1 <= m[0]; r1c2 <= m[1]; r1c3 <= m[2];
    r2c1 <= m[3]; r2c2 <= m[4]; r2c3 <= m[5];
    r3c1 <= m[6]; r3c2 <= m[7]; r3c3 <= m[8];
    do @(posedge clk); while (busy);
    expected_quats.push_back(predict_quaternion(m));
  endtask

  // Result checker: the strobe is sampled at the edge that takes the result.
  always @(posedge clk) begin
    quat_t want;
    if (!rst && strobe) begin
      if (expected_quats.size() == 0) begin
        $display("MISMATCH: quaternion output with no transaction pending");
        mismatches++;
      end else begin
        want = expected_quats.pop_front();
        if (quat_x !== want.x) report_mismatch("quat_x", quat_x, want.x);
        if (quat_y !== want.y) report_mismatch("quat_y", quat_y, want.y);
        if (quat_z !== want.z) report_mismatch("quat_z", quat_z, want.z);
        if (quat_w !== want.w) report_mismatch("quat_w", quat_w, want.w);
      end
    end
  end

  // Watchdog: counts cycles in which neither an input nor a result is accepted.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic sample_t random_sample();
    return sample_t'($urandom);
  endfunction

  // Extremes, identity, and the dominant diagonal cases, including the
  // all-equal tie that falls through to the r3c3 case.
  task automatic test_directed();
    sample_t m[9];
    sample_t mx, mn;
    mx = sample_t'(UNIT - 1);
    mn = sample_t'(-UNIT);
    m = '{mx, 0, 0, 0, mx, 0, 0, 0, mx}; send_matrix(m);
    m = '{mx, 0, 0, 0, mn, 0, 0, 0, mn}; send_matrix(m);
    m = '{mn, 0, 0, 0, mx, 0, 0, 0, mn}; send_matrix(m);
    m = '{mn, 0, 0, 0, mn, 0, 0, 0, mx}; send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);
    m = '{mn, mn, mn, mn, mn, mn, mn, mn, mn}; send_matrix(m);
    m = '{mx, mx, mx, mx, mx, mx, mx, mx, mx}; send_matrix(m);
    m = '{mn, mx, mn, mx, mn, mx, mn, mx, mn}; send_matrix(m);
    m = '{mn, mx, mx, mn, mn, mx, mx, mn, mn}; send_matrix(m);
    m = '{mx, mx, mx, mn, mn, mn, mx, mn, mn}; send_matrix(m);
    // Negative diagonal terms with full-scale off-diagonal terms.
    m = '{-16384, mn, mx, mx, -16384, mn, mn, mx, -16384}; send_matrix(m);
    m = '{mn, mx, mx, mn, -16384, mx, mx, mn, -16384}; send_matrix(m);
    m = '{1, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);
    m = '{0, mx, 0, mn, 0, 0, 0, 0, 0}; send_matrix(m);
    m = '{-1, 16'sh5555, 16'shAAAA, 16'sh5555, -1, 16'shAAAA, 16'sh5555, 16'shAAAA, -1};
    send_matrix(m);
  endtask

  // Structured matrices: a dominant diagonal term near one, or two non-positive diagonal terms, plus
  // a share of fully random matrices as noise.
  task automatic test_random(int count);
    sample_t m[9];
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      foreach (m[i]) m[i] = random_sample();
      if (kind < 4) begin
        // Dominant diagonal near one, random small off-diagonal terms.
        foreach (m[i]) m[i] = sample_t'($signed($urandom_range(0, 16383)) - 8192);
        m[4 * $urandom_range(0, 2)] = sample_t'($urandom_range(24000, 32767));
      end else if (kind < 7) begin
        // Two diagonal terms between minus one and zero, the third between zero and one.
        m[0] = sample_t'(-$signed($urandom_range(0, 32768)));
        m[4] = sample_t'(-$signed($urandom_range(0, 32768)));
        m[8] = sample_t'(-$signed($urandom_range(0, 32768)));
        m[4 * $urandom_range(0, 2)] = sample_t'($urandom_range(0, 32767));
      end
      send_matrix(m);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1150);
    start <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && expected_quats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rmq_pkg.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion.sv
rtl/rmq_checker.sv
verif/rotation_matrix_to_quaternion_test.sv
